FILE: sv/u8v_pkg.sv
// Shared types, constants and the invisible-character lookup for the UTF-8 flagger.
`default_nettype none

package u8v_pkg;

  localparam int OffsetBits  = 32;
  localparam int OutOffBits  = 32;
  localparam int MaxResults  = 4;
  localparam int CountBits   = 3;
  localparam int CodeBits    = 21;

  localparam logic [CodeBits-1:0] CodeMax       = 21'h10ffff;
  localparam logic [CodeBits-1:0] SurrogateLo   = 21'h00d800;
  localparam logic [CodeBits-1:0] SurrogateHi   = 21'h00dfff;
  localparam logic [CodeBits-1:0] ByteOrderMark = 21'h00feff;
  localparam logic [CodeBits-1:0] Least2        = 21'h000080;
  localparam logic [CodeBits-1:0] Least3        = 21'h000800;
  localparam logic [CodeBits-1:0] Least4        = 21'h010000;

  typedef enum logic [2:0] {
    FindBad       = 3'd0,
    FindSpace     = 3'd1,
    FindHyphen    = 3'd2,
    FindZeroWidth = 3'd3,
    FindDirection = 3'd4,
    FindLineSep   = 3'd5
  } finding_e;

  typedef struct packed {
    logic [OutOffBits-1:0] offset;
    logic [2:0]            span;
    finding_e              finding;
    logic [7:0]            bad;
    logic [CodeBits-1:0]   code;
    logic                  mark;
  } result_t;

  typedef struct packed {
    logic                 load;
    logic [CountBits-1:0] count;
  } load_t;

  function automatic finding_e inv_kind(input logic [CodeBits-1:0] c);
    finding_e k;
    k = FindBad;
    priority if (c == 21'h00a0) k = FindSpace;
    else if (c == 21'h00ad) k = FindHyphen;
    else if (c == 21'h1680) k = FindSpace;
    else if (c >= 21'h2000 && c <= 21'h200a) k = FindSpace;
    else if (c >= 21'h200b && c <= 21'h200d) k = FindZeroWidth;
    else if (c >= 21'h200e && c <= 21'h200f) k = FindDirection;
    else if (c >= 21'h2028 && c <= 21'h2029) k = FindLineSep;
    else if (c >= 21'h202a && c <= 21'h202e) k = FindDirection;
    else if (c == 21'h202f) k = FindSpace;
    else if (c == 21'h205f) k = FindSpace;
    else if (c >= 21'h2060 && c <= 21'h2064) k = FindZeroWidth;
    else if (c >= 21'h2066 && c <= 21'h2069) k = FindDirection;
    else if (c == 21'h3000) k = FindSpace;
    else if (c == ByteOrderMark) k = FindZeroWidth;
    else k = FindBad;
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: sv/utf8_validator_invisible_flagger_core.sv
// Top level of the UTF-8 validator and invisible-character flagger.
`default_nettype none

// Takes one file byte per beat while in_stall_o is low and decodes UTF-8
// on the fly: the byte is checked against the pending sequence state in
// the same cycle it is accepted, and its findings (zero to four) are
// loaded into a four-entry result bank. The bank drains one finding per
// beat while out_stall_i is low; the input stays stalled until the last
// finding of the bank is taken. Each finding reports its offset, span, kind,
// the bad byte or the decoded code point, a byte-order-mark-at-start flag,
// and last_of_run on the final finding of a byte. The byte after the one
// marked end_of_text starts a new file at 0.
module utf8_validator_invisible_flagger_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  byte_in_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      offset_o,
  output logic [2:0]       span_length_o,
  output logic [2:0]       finding_o,
  output logic [7:0]       bad_byte_o,
  output logic [20:0]      code_point_o,
  output logic             mark_at_start_o,
  output logic             last_of_run_o
);

  localparam int OB = u8v_pkg::OffsetBits;
  localparam int CB = u8v_pkg::CodeBits;

  logic [OB-1:0] byte_pos_q, byte_pos_d;
  logic [OB-1:0] lead_pos_q, lead_pos_d;
  logic [7:0]    lead_byte_q, lead_byte_d;
  logic [2:0]    ew_q, ew_d;
  logic [1:0]    cs_q, cs_d;
  logic [CB-1:0] partial_q, partial_d;
  logic [7:0]    held_q [3];

  logic accept, free, pending, is_cont, complete, range_bad, fail;
  logic lead2, lead3, lead4, is_lead, fresh_bad, fresh_start;
  logic fresh_path, emit_fresh, emit_inv;
  logic [1:0]    cs_new, fail_n;
  logic [2:0]    fresh_w, fail_cnt;
  logic [CB-1:0] fresh_v, v_new, least;
  logic [7:0]    held_ext [3];
  u8v_pkg::finding_e kind;
  u8v_pkg::result_t  fail_ent [u8v_pkg::MaxResults];
  u8v_pkg::result_t  slot     [u8v_pkg::MaxResults];
  u8v_pkg::result_t  fresh_ent, inv_ent, out_ent;
  u8v_pkg::load_t    load;

  assign accept  = in_valid_i && free;
  assign pending = (ew_q != 3'd0);
  assign is_cont = (byte_in_i[7:6] == 2'b10);

  assign lead2   = (byte_in_i[7:5] == 3'b110);
  assign lead3   = (byte_in_i[7:4] == 4'b1110);
  assign lead4   = (byte_in_i[7:3] == 5'b11110);
  assign is_lead = lead2 || lead3 || lead4;
  assign fresh_bad   = byte_in_i[7] && (!is_lead || end_of_text_i);
  assign fresh_start = is_lead && !end_of_text_i;

  always_comb begin
    priority if (lead2) begin
      fresh_w = 3'd2;
      fresh_v = CB'(byte_in_i[4:0]);
    end else if (lead3) begin
      fresh_w = 3'd3;
      fresh_v = CB'(byte_in_i[3:0]);
    end else begin
      fresh_w = 3'd4;
      fresh_v = CB'(byte_in_i[2:0]);
    end
  end

  assign cs_new   = cs_q + 2'd1;
  assign complete = ((3'(cs_new) + 3'd1) == ew_q);
  assign v_new    = {partial_q[CB-7:0], byte_in_i[5:0]};

  always_comb begin
    unique case (ew_q)
      3'd2:    least = u8v_pkg::Least2;
      3'd3:    least = u8v_pkg::Least3;
      default: least = u8v_pkg::Least4;
    endcase
  end

  assign range_bad = (v_new < least) || (v_new > u8v_pkg::CodeMax) ||
                     ((v_new >= u8v_pkg::SurrogateLo) && (v_new <= u8v_pkg::SurrogateHi));
  assign kind = u8v_pkg::inv_kind(v_new);

  assign fail = pending && (!is_cont || (complete ? range_bad : end_of_text_i));
  assign fail_n   = is_cont ? cs_new : cs_q;
  assign fail_cnt = fail ? (3'd1 + 3'(fail_n)) : 3'd0;
  assign fresh_path = !pending || !is_cont;
  assign emit_fresh = fresh_path && fresh_bad;
  assign emit_inv   = pending && is_cont && complete && !range_bad &&
                      (kind != u8v_pkg::FindBad);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      held_ext[i] = (is_cont && (cs_q == 2'(i))) ? byte_in_i : held_q[i];
    end
  end

  always_comb begin
    fresh_ent = '{offset: 32'(byte_pos_q), span: 3'd1, finding: u8v_pkg::FindBad,
                  bad: byte_in_i, code: '0, mark: 1'b0};
    inv_ent   = '{offset: 32'(lead_pos_q), span: ew_q, finding: kind, bad: 8'd0,
                  code: v_new,
                  mark: (v_new == u8v_pkg::ByteOrderMark) && (lead_pos_q == '0)};
    fail_ent[0] = '{offset: 32'(lead_pos_q), span: 3'd1, finding: u8v_pkg::FindBad,
                    bad: lead_byte_q, code: '0, mark: 1'b0};
    for (int j = 1; j < u8v_pkg::MaxResults; j++) begin
      fail_ent[j] = '{offset: 32'(lead_pos_q + OB'(j)), span: 3'd1,
                      finding: u8v_pkg::FindBad, bad: held_ext[j-1], code: '0,
                      mark: 1'b0};
    end
    for (int j = 0; j < u8v_pkg::MaxResults; j++) begin
      if (3'(j) < fail_cnt) begin
        slot[j] = fail_ent[j];
      end else if (emit_inv) begin
        slot[j] = inv_ent;
      end else begin
        slot[j] = fresh_ent;
      end
    end
  end

  assign load.load  = accept;
  assign load.count = fail_cnt + 3'(emit_fresh) + 3'(emit_inv);

  always_comb begin
    byte_pos_d  = byte_pos_q;
    lead_pos_d  = lead_pos_q;
    lead_byte_d = lead_byte_q;
    ew_d        = ew_q;
    cs_d        = cs_q;
    partial_d   = partial_q;
    if (accept) begin
      byte_pos_d = end_of_text_i ? '0 : byte_pos_q + OB'(1);
      if (pending && is_cont) begin
        cs_d      = cs_new;
        partial_d = v_new;
        if (complete) begin
          ew_d      = 3'd0;
          cs_d      = 2'd0;
          partial_d = '0;
        end
      end else begin
        ew_d      = 3'd0;
        cs_d      = 2'd0;
        partial_d = '0;
        if (fresh_start) begin
          lead_byte_d = byte_in_i;
          lead_pos_d  = byte_pos_q;
          ew_d        = fresh_w;
          partial_d   = fresh_v;
        end
      end
      if (end_of_text_i) begin
        ew_d      = 3'd0;
        cs_d      = 2'd0;
        partial_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q  <= '0;
      lead_pos_q  <= '0;
      lead_byte_q <= '0;
      ew_q        <= '0;
      cs_q        <= '0;
      partial_q   <= '0;
    end else begin
      byte_pos_q  <= byte_pos_d;
      lead_pos_q  <= lead_pos_d;
      lead_byte_q <= lead_byte_d;
      ew_q        <= ew_d;
      cs_q        <= cs_d;
      partial_q   <= partial_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pending && is_cont) begin
      held_q[cs_q] <= byte_in_i;
    end
  end

  u8v_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .entries_i   (slot),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_o       (out_ent),
    .last_o      (last_of_run_o)
  );

  assign in_stall_o      = !free;
  assign offset_o        = out_ent.offset;
  assign span_length_o   = out_ent.span;
  assign finding_o       = out_ent.finding;
  assign bad_byte_o      = out_ent.bad;
  assign code_point_o    = out_ent.code;
  assign mark_at_start_o = out_ent.mark;

endmodule

`default_nettype wire

FILE: sv/u8v_outq.sv
// Result bank: holds a byte's findings, drains one beat per cycle unless stalled.
`default_nettype none

module u8v_outq (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire u8v_pkg::load_t   load_i,
  input  wire u8v_pkg::result_t entries_i [u8v_pkg::MaxResults],
  input  wire logic             out_stall_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  output u8v_pkg::result_t      out_o,
  output logic                  last_o
);

  u8v_pkg::result_t bank_q [u8v_pkg::MaxResults];
  logic [u8v_pkg::CountBits-1:0] rem_q, rem_d;
  logic [$clog2(u8v_pkg::MaxResults)-1:0] rd_q, rd_d;
  logic pop;
  logic do_load;

  assign out_valid_o = (rem_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign free_o      = (rem_q == '0) || ((rem_q == u8v_pkg::CountBits'(1)) && pop);
  assign do_load     = load_i.load && free_o;
  assign out_o       = bank_q[rd_q];
  assign last_o      = (rem_q == u8v_pkg::CountBits'(1));

  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (do_load) begin
      rem_d = load_i.count;
      rd_d  = '0;
    end else if (pop) begin
      rem_d = rem_q - u8v_pkg::CountBits'(1);
      rd_d  = rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      rd_q  <= '0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      bank_q <= entries_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/u8v_checker.sv
// Port-level checks for the UTF-8 flagger, bound to the top level.
`default_nettype none

module u8v_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  byte_in_i,
  input wire logic        end_of_text_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [31:0] offset_o,
  input wire logic [2:0]  span_length_o,
  input wire logic [2:0]  finding_o,
  input wire logic [7:0]  bad_byte_o,
  input wire logic [20:0] code_point_o,
  input wire logic        mark_at_start_o,
  input wire logic        last_of_run_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(offset_o) &&
      $stable(finding_o) && $stable(bad_byte_o) && $stable(code_point_o) &&
      $stable(last_of_run_o))
    else $error("stalled result beat changed");

  a_stall_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (finding_o == u8v_pkg::FindBad) |->
      (span_length_o == 3'd1) && (code_point_o == 21'd0) && !mark_at_start_o)
    else $error("bad-byte beat malformed");

  a_inv_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (finding_o != u8v_pkg::FindBad) |->
      (bad_byte_o == 8'd0) && (span_length_o >= 3'd2) && (span_length_o <= 3'd4))
    else $error("invisible-character beat malformed");

  a_mark_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mark_at_start_o |->
      (code_point_o == u8v_pkg::ByteOrderMark) && (offset_o == 32'd0) &&
      (finding_o == u8v_pkg::FindZeroWidth))
    else $error("start mark beat malformed");

endmodule

bind utf8_validator_invisible_flagger_core u8v_checker u_chk (.*);

`default_nettype wire

FILE: tb/utf8_validator_invisible_flagger_core_tb.sv
// Testbench for the UTF-8 validator and invisible-character flagger core.
module utf8_validator_invisible_flagger_core_tb;
  import u8v_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int LongHold   = 80;
  localparam int HoldAfter  = 100;

  typedef struct packed {
    logic [7:0]  b;
    logic        eot;
    logic        typed;
    logic        has_bad;
    logic [31:0] off;
  } row_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [2:0]  span;
    finding_e    finding;
    logic [7:0]  bad;
    logic [20:0] code;
    logic        mark;
    logic        last;
  } finding_rec_t;

  localparam row_t DirectedBytes [26] = '{
    '{8'hef, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hbb, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hbf, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'd0},
    '{8'h7f, 1'b0, 1'b1, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b1, 1'b1, 32'd5},
    '{8'hff, 1'b0, 1'b1, 1'b1, 32'd6},
    '{8'hc2, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'had, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hc0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'he2, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'ha8, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hed, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'ha0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hf4, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h90, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'he2, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h41, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hf0, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'h9f, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'hf0, 1'b1, 1'b1, 1'b1, 32'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  byte_in_i = 8'd0;
  logic        end_of_text_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] offset_o;
  logic [2:0]  span_length_o;
  logic [2:0]  finding_o;
  logic [7:0]  bad_byte_o;
  logic [20:0] code_point_o;
  logic        mark_at_start_o;
  logic        last_of_run_o;

  row_t         byte_queue [$];
  row_t         cur;
  finding_rec_t findings_due [$];
  finding_rec_t byte_findings [$];
  int           errors = 0;
  int           bytes_taken = 0;
  int           burst_left = 0;
  int           gap_left = 0;
  int           stall_pct = 0;
  int           hold_cnt = 0;
  int           quiet_cycles = 0;
  logic [5:0]   phase_cnt = 6'd0;

  // decoder state
  logic [31:0]  dec_pos = 32'd0;
  logic [31:0]  lead_pos = 32'd0;
  logic [7:0]   lead_b = 8'd0;
  logic [2:0]   want_w = 3'd0;
  logic [1:0]   seen = 2'd0;
  logic [7:0]   held [3];
  logic [20:0]  partial = 21'd0;

  always #1 clk_i = ~clk_i;

  utf8_validator_invisible_flagger_core u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .byte_in_i      (byte_in_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .offset_o       (offset_o),
    .span_length_o  (span_length_o),
    .finding_o      (finding_o),
    .bad_byte_o     (bad_byte_o),
    .code_point_o   (code_point_o),
    .mark_at_start_o(mark_at_start_o),
    .last_of_run_o  (last_of_run_o)
  );

  function automatic logic [20:0] floor_of(int w);
    return (w == 2) ? Least2 : (w == 3) ? Least3 : Least4;
  endfunction

  function automatic finding_e invisible_kind(logic [20:0] c);
    if (c inside {21'h00a0, 21'h1680, [21'h2000:21'h200a], 21'h202f, 21'h205f, 21'h3000})
      return FindSpace;
    if (c == 21'h00ad) return FindHyphen;
    if (c inside {[21'h200b:21'h200d], [21'h2060:21'h2064], ByteOrderMark})
      return FindZeroWidth;
    if (c inside {[21'h200e:21'h200f], [21'h202a:21'h202e], [21'h2066:21'h2069]})
      return FindDirection;
    if (c inside {21'h2028, 21'h2029}) return FindLineSep;
    return FindBad;
  endfunction

  function automatic void note(logic [31:0] off, logic [2:0] span, finding_e kind,
                               logic [7:0] bad, logic [20:0] code, logic mark);
    finding_rec_t r;
    r.offset  = off;
    r.span    = span;
    r.finding = kind;
    r.bad     = bad;
    r.code    = code;
    r.mark    = mark;
    r.last    = 1'b0;
    byte_findings.push_back(r);
  endfunction

  function automatic void clear_seq();
    want_w  = 3'd0;
    seen    = 2'd0;
    partial = 21'd0;
  endfunction

  function automatic void reject_sequence();
    int i;
    note(lead_pos, 3'd1, FindBad, lead_b, 21'd0, 1'b0);
    for (i = 0; i < int'(seen); i++)
      note(lead_pos + 32'(i) + 32'd1, 3'd1, FindBad, held[i], 21'd0, 1'b0);
    clear_seq();
  endfunction

  function automatic void start_byte(logic [7:0] b, logic [31:0] at, logic eot);
    logic [2:0]  w;
    logic [20:0] v;
    if (!b[7]) return;
    if (b[7:5] == 3'b110) begin
      w = 3'd2;
      v = {16'd0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      w = 3'd3;
      v = {17'd0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      w = 3'd4;
      v = {18'd0, b[2:0]};
    end else begin
      note(at, 3'd1, FindBad, b, 21'd0, 1'b0);
      return;
    end
    if (eot) begin
      note(at, 3'd1, FindBad, b, 21'd0, 1'b0);
      return;
    end
    lead_b   = b;
    lead_pos = at;
    want_w   = w;
    seen     = 2'd0;
    partial  = v;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eot);
    logic [20:0] v;
    finding_e    kind;
    byte_findings.delete();
    if (want_w >= 3'd2) begin
      if (b[7:6] == 2'b10 && seen < 2'd3) begin
        held[seen] = b;
        seen = seen + 2'd1;
        partial = {partial[14:0], b[5:0]};
        if (int'(seen) + 1 == int'(want_w)) begin
          v = partial;
          if (v < floor_of(want_w) || v > CodeMax || (v >= SurrogateLo && v <= SurrogateHi)) begin
            reject_sequence();
          end else begin
            kind = invisible_kind(v);
            if (kind != FindBad)
              note(lead_pos, want_w, kind, 8'd0, v, v == ByteOrderMark && lead_pos == 32'd0);
            clear_seq();
          end
        end else if (eot) begin
          reject_sequence();
        end
      end else begin
        reject_sequence();
        start_byte(b, dec_pos, eot);
      end
    end else begin
      clear_seq();
      start_byte(b, dec_pos, eot);
    end
    if (eot) begin
      dec_pos = 32'd0;
      clear_seq();
    end else begin
      dec_pos = dec_pos + 32'd1;
    end
    if (byte_findings.size() != 0) byte_findings[byte_findings.size() - 1].last = 1'b1;
  endfunction

  function automatic int field_diff(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  function automatic logic [20:0] pick_invisible();
    case ($urandom_range(0, 9))
      0: return 21'h00a0;
      1: return 21'h00ad;
      2: return 21'h1680;
      3: return 21'($urandom_range(32'h2000, 32'h202f));
      4: return 21'($urandom_range(32'h205f, 32'h206a));
      5: return 21'h3000;
      6: return ByteOrderMark;
      7: return 21'($urandom_range(32'h009f, 32'h00ae));
      8: return 21'($urandom_range(32'hfefe, 32'hff00));
      default: return 21'($urandom_range(32'h2000, 32'h206f));
    endcase
  endfunction

  function automatic int push_char(logic [20:0] v, int w, int keep, logic eot_last);
    logic [7:0] enc [4];
    row_t       r;
    int         i;
    case (w)
      1: enc[0] = {1'b0, v[6:0]};
      2: begin
        enc[0] = {3'b110, v[10:6]};
        enc[1] = {2'b10, v[5:0]};
      end
      3: begin
        enc[0] = {4'b1110, v[15:12]};
        enc[1] = {2'b10, v[11:6]};
        enc[2] = {2'b10, v[5:0]};
      end
      default: begin
        enc[0] = {5'b11110, v[20:18]};
        enc[1] = {2'b10, v[17:12]};
        enc[2] = {2'b10, v[11:6]};
        enc[3] = {2'b10, v[5:0]};
      end
    endcase
    for (i = 0; i < keep; i++) begin
      r = '0;
      r.b = enc[i];
      r.eot = eot_last && (i == keep - 1);
      byte_queue.push_back(r);
    end
    return keep;
  endfunction

  task automatic queue_random(int n);
    int          added;
    int          r;
    int          w;
    int          keep;
    int          extra;
    logic [20:0] v;
    logic        eot_end;
    logic        bom_next;
    row_t        raw;
    added = 0;
    bom_next = 1'b0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      eot_end = ($urandom_range(0, 24) == 0);
      extra = 0;
      if (bom_next) begin
        v = ByteOrderMark;
        w = 3;
      end else if (r < 25) begin
        v = 21'($urandom_range(0, 127));
        w = 1;
      end else if (r < 50) begin
        v = pick_invisible();
        w = (v < 21'h800) ? 2 : 3;
      end else if (r < 63 || (r >= 73 && r < 90)) begin
        w = $urandom_range(2, 4);
        v = 21'($urandom_range(floor_of(w), (w == 2) ? 32'h7ff : (w == 3) ? 32'hffff : 32'h10ffff));
        if (r >= 83) extra = $urandom_range(1, 2);
      end else if (r < 73) begin
        case ($urandom_range(0, 2))
          0: begin
            w = $urandom_range(2, 4);
            v = 21'($urandom_range(0, floor_of(w) - 1));
          end
          1: begin
            w = 3;
            v = 21'($urandom_range(SurrogateLo, SurrogateHi));
          end
          default: begin
            w = 4;
            v = 21'($urandom_range(32'h110000, 32'h1fffff));
          end
        endcase
      end else begin
        w = 0;
        v = 21'd0;
      end
      keep = w;
      if (r >= 73 && r < 83 && !bom_next) keep = $urandom_range(1, w - 1);
      bom_next = 1'b0;
      if (w == 0) begin
        raw = '0;
        raw.b = 8'($urandom_range(0, 255));
        raw.eot = eot_end;
        byte_queue.push_back(raw);
        added++;
      end else begin
        added += push_char(v, w, keep, eot_end && extra == 0);
      end
      while (extra != 0) begin
        raw = '0;
        raw.b = {2'b10, 6'($urandom_range(0, 63))};
        raw.eot = eot_end && extra == 1;
        byte_queue.push_back(raw);
        added++;
        extra--;
      end
      if (eot_end && $urandom_range(0, 2) == 0) bom_next = 1'b1;
    end
  endtask

  task automatic drain();
    while (byte_queue.size() != 0 || in_valid_i || findings_due.size() != 0)
      @(negedge clk_i);
  endtask

  // sender: bursts of beats with random gaps
  always @(posedge clk_i) begin
    row_t nxt;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      byte_in_i     <= 8'd0;
      end_of_text_i <= 1'b0;
      burst_left    <= 0;
      gap_left      <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        decode_byte(byte_in_i, end_of_text_i);
        if (cur.typed) begin
          if (cur.has_bad)
            findings_due.push_back('{cur.off, 3'd1, FindBad, cur.b, 21'd0, 1'b0, 1'b1});
        end else begin
          foreach (byte_findings[k]) findings_due.push_back(byte_findings[k]);
        end
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0 || byte_queue.size() == 0) begin
          in_valid_i <= 1'b0;
          if (gap_left != 0) gap_left <= gap_left - 1;
        end else begin
          nxt = byte_queue.pop_front();
          cur           <= nxt;
          in_valid_i    <= 1'b1;
          byte_in_i     <= nxt.b;
          end_of_text_i <= nxt.eot;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver: stall pattern plus one long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (bytes_taken >= HoldAfter && hold_cnt < LongHold) begin
      out_stall_i <= 1'b1;
      hold_cnt    <= hold_cnt + 1;
    end else begin
      phase_cnt <= phase_cnt + 6'd1;
      if (phase_cnt == 6'd0) begin
        case ($urandom_range(0, 4))
          0, 1: stall_pct <= 0;
          2: stall_pct <= 30;
          3: stall_pct <= 60;
          default: stall_pct <= 85;
        endcase
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    finding_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (findings_due.size() == 0) begin
        $display("%0t: unexpected beat, offset %0h finding %0d bad %0h code %0h",
                 $time, offset_o, finding_o, bad_byte_o, code_point_o);
        errors++;
      end else begin
        want = findings_due.pop_front();
        errors += field_diff("offset", want.offset, offset_o);
        errors += field_diff("span_length", 32'(want.span), 32'(span_length_o));
        errors += field_diff("finding", 32'(want.finding), 32'(finding_o));
        errors += field_diff("bad_byte", 32'(want.bad), 32'(bad_byte_o));
        errors += field_diff("code_point", 32'(want.code), 32'(code_point_o));
        errors += field_diff("mark_at_start", 32'(want.mark), 32'(mark_at_start_o));
        errors += field_diff("last_of_run", 32'(want.last), 32'(last_of_run_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QuietLimit) begin
      $display("%0t: no progress, %0d results outstanding", $time, findings_due.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DirectedBytes[i]) byte_queue.push_back(DirectedBytes[i]);
    drain();
    queue_random(130);
    drain();
    queue_random(130);
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && findings_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/u8v_pkg.sv
sv/u8v_outq.sv
sv/utf8_validator_invisible_flagger_core.sv
sv/u8v_checker.sv
tb/utf8_validator_invisible_flagger_core_tb.sv
